FILE: rtl/bba_pkg.sv
`default_nettype none
package bba_pkg;

    localparam int IDX_W        = 12;
    localparam int LINK_W       = 13;
    localparam int ORD_W        = 4;
    localparam int CNT_W        = 13;
    localparam int ORDER_LEVELS = 13;
    localparam int MAX_BLOCKS   = 4096;
    localparam int BLOCK_SHIFT  = 12;
    localparam int BLOCK_BYTES  = 4096;
    localparam int BYTES_W      = 24;
    localparam int HDR_W        = 12;
    localparam int SUM_W        = 26;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_BLOCKS);

    localparam logic [1:0] RQ_ALLOC = 2'd0;
    localparam logic [1:0] RQ_FREE  = 2'd1;
    localparam logic [1:0] RQ_INIT  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_OVER     = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    localparam logic CFG_TOTAL  = 1'b0;
    localparam logic CFG_HEADER = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [BYTES_W-1:0] request_bytes;
        logic [IDX_W-1:0]   free_index;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] block_index;
        logic [ORD_W-1:0] block_order;
    } res_t;

    function automatic logic [ORD_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
        logic [ORD_W-1:0] r;
        r = '0;
        for (int k = 0; k < CNT_W; k++)
        begin
            if (v[k])
            begin
                r = ORD_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [ORD_W-1:0] ceil_log2(input logic [CNT_W-1:0] v);
        logic [ORD_W-1:0] r;
        if (v <= CNT_W'(1))
        begin
            r = '0;
        end
        else
        begin
            r = floor_log2(v - CNT_W'(1)) + ORD_W'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bba_core.sv
`default_nettype none
module bba_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire bba_pkg::req_t             req,
    input  wire logic [bba_pkg::CNT_W-1:0] total_blocks,
    input  wire logic [bba_pkg::HDR_W-1:0] header_bytes,
    output logic                           res_valid,
    input  wire logic                      res_ready,
    output bba_pkg::res_t                  res
);
    import bba_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE    = 15'h0001,
        S_CLEAR   = 15'h0002,
        S_A_SIZE  = 15'h0004,
        S_A_SRCH  = 15'h0008,
        S_A_POP   = 15'h0010,
        S_A_SPLIT = 15'h0020,
        S_F_CHK   = 15'h0040,
        S_F_MRG   = 15'h0080,
        S_F_BUD   = 15'h0100,
        S_U_RD    = 15'h0200,
        S_U_CHK   = 15'h0400,
        S_F_PUSH  = 15'h0800,
        S_I_START = 15'h1000,
        S_I_TAIL  = 15'h2000,
        S_DONE    = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic              init_reg, init_next;
    logic [CNT_W-1:0]  usable_reg, usable_next;
    logic [CNT_W-1:0]  blk_reg, blk_next;
    logic [ORD_W-1:0]  ord_reg, ord_next;
    logic [ORD_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  bud_reg, bud_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic [CNT_W-1:0]  start_reg, start_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [ORD_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  area_reg, area_next;
    res_t              res_reg, res_next;

    logic [LINK_W-1:0] head_reg [ORDER_LEVELS];
    logic              head_we, head_clr;
    logic [ORD_W-1:0]  head_wa;
    logic [LINK_W-1:0] head_wd;

    logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
    logic [ORD_W-1:0]  ord_mem  [MAX_BLOCKS];
    logic              fm_mem   [MAX_BLOCKS];
    logic              am_mem   [MAX_BLOCKS];

    logic [IDX_W-1:0]  rd_addr;
    logic [LINK_W-1:0] link_rd;
    logic [ORD_W-1:0]  ord_rd;
    logic              fm_rd, am_rd;

    logic              link_we, ord_we, fm_we, am_we;
    logic [IDX_W-1:0]  link_wa, ord_wa, fm_wa, am_wa;
    logic [LINK_W-1:0] link_wd;
    logic [ORD_W-1:0]  ord_wd;
    logic              fm_wd, am_wd;

    logic              push_en;
    logic [IDX_W-1:0]  push_idx;
    logic [ORD_W-1:0]  push_ord;

    logic [SUM_W-1:0]  size_sum;
    logic [CNT_W-1:0]  blk_calc;
    logic [LINK_W-1:0] head_sel;
    logic [IDX_W-1:0]  bud_size;
    logic [IDX_W-1:0]  bud_calc;
    logic [ORD_W-1:0]  fl_val;
    logic [CNT_W-1:0]  fl_pow;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    assign size_sum = SUM_W'(req.request_bytes) + SUM_W'(header_bytes)
                    + SUM_W'(BLOCK_BYTES - 1);
    assign blk_calc = CNT_W'(size_sum >> BLOCK_SHIFT);
    assign head_sel = (i_reg < ORD_W'(ORDER_LEVELS)) ? head_reg[i_reg] : NIL_LINK;
    assign bud_size = IDX_W'(1) << ord_reg;
    assign bud_calc = idx_reg ^ bud_size;
    assign fl_val   = floor_log2((state_reg == S_I_START) ? usable_reg : rem_reg);
    assign fl_pow   = CNT_W'(1) << fl_val;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        init_next   = init_reg;
        usable_next = usable_reg;
        blk_next    = blk_reg;
        ord_next    = ord_reg;
        i_next      = i_reg;
        idx_next    = idx_reg;
        bud_next    = bud_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        steps_next  = steps_reg;
        start_next  = start_reg;
        rem_next    = rem_reg;
        top_next    = top_reg;
        area_next   = area_reg;
        res_next    = res_reg;
        rd_addr     = idx_reg;
        head_clr    = 1'b0;
        head_we     = 1'b0;
        head_wa     = '0;
        head_wd     = NIL_LINK;
        link_we     = 1'b0;
        link_wa     = '0;
        link_wd     = '0;
        ord_we      = 1'b0;
        ord_wa      = '0;
        ord_wd      = '0;
        fm_we       = 1'b0;
        fm_wa       = '0;
        fm_wd       = 1'b0;
        am_we       = 1'b0;
        am_wa       = '0;
        am_wd       = 1'b0;
        push_en     = 1'b0;
        push_idx    = '0;
        push_ord    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.req_type)
                        RQ_ALLOC:
                        begin
                            blk_next   = (blk_calc == '0) ? CNT_W'(1) : blk_calc;
                            state_next = S_A_SIZE;
                        end
                        RQ_FREE:
                        begin
                            idx_next   = req.free_index;
                            rd_addr    = req.free_index;
                            state_next = S_F_CHK;
                        end
                        RQ_INIT:
                        begin
                            head_clr    = 1'b1;
                            top_next    = '0;
                            area_next   = '0;
                            usable_next = (total_blocks == '0) ? '0 : total_blocks - CNT_W'(1);
                            init_next   = 1'b1;
                            clr_next    = '0;
                            state_next  = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                fm_we    = 1'b1;
                fm_wa    = clr_reg;
                am_we    = 1'b1;
                am_wa    = clr_reg;
                clr_next = clr_reg + IDX_W'(1);
                if (&clr_reg)
                begin
                    state_next = init_reg ? S_I_START : S_IDLE;
                    init_next  = 1'b0;
                end
            end
            S_A_SIZE:
            begin
                ord_next   = ceil_log2(blk_reg);
                i_next     = ceil_log2(blk_reg);
                state_next = S_A_SRCH;
            end
            S_A_SRCH:
            begin
                if (i_reg > top_reg)
                begin
                    res_next   = '{status: ST_NO_SPACE, block_index: '0, block_order: '0};
                    state_next = S_DONE;
                end
                else if (head_sel[IDX_W])
                begin
                    i_next = i_reg + ORD_W'(1);
                end
                else
                begin
                    idx_next   = head_sel[IDX_W-1:0];
                    rd_addr    = head_sel[IDX_W-1:0];
                    state_next = S_A_POP;
                end
            end
            S_A_POP:
            begin
                head_we    = 1'b1;
                head_wa    = i_reg;
                head_wd    = link_rd;
                fm_we      = 1'b1;
                fm_wa      = idx_reg;
                state_next = S_A_SPLIT;
            end
            S_A_SPLIT:
            begin
                if (i_reg > ord_reg)
                begin
                    push_en  = 1'b1;
                    push_ord = i_reg - ORD_W'(1);
                    push_idx = idx_reg + (IDX_W'(1) << push_ord);
                    i_next   = i_reg - ORD_W'(1);
                end
                else
                begin
                    ord_we     = 1'b1;
                    ord_wa     = idx_reg;
                    ord_wd     = ord_reg;
                    am_we      = 1'b1;
                    am_wa      = idx_reg;
                    am_wd      = 1'b1;
                    res_next   = '{status: ST_OK, block_index: idx_reg, block_order: ord_reg};
                    state_next = S_DONE;
                end
            end
            S_F_CHK:
            begin
                if (!am_rd)
                begin
                    res_next   = '{status: ST_BAD_FREE, block_index: idx_reg, block_order: '0};
                    state_next = S_DONE;
                end
                else
                begin
                    am_we      = 1'b1;
                    am_wa      = idx_reg;
                    ord_next   = ord_rd;
                    state_next = S_F_MRG;
                end
            end
            S_F_MRG:
            begin
                if (ord_reg >= top_reg)
                begin
                    state_next = S_F_PUSH;
                end
                else if ((CNT_W'(bud_calc) + CNT_W'(bud_size)) > area_reg)
                begin
                    state_next = S_F_PUSH;
                end
                else
                begin
                    bud_next   = bud_calc;
                    rd_addr    = bud_calc;
                    state_next = S_F_BUD;
                end
            end
            S_F_BUD:
            begin
                if (!fm_rd || ord_rd != ord_reg)
                begin
                    state_next = S_F_PUSH;
                end
                else
                begin
                    cur_next   = head_reg[ord_reg];
                    prev_next  = NIL_LINK;
                    steps_next = '0;
                    state_next = S_U_RD;
                end
            end
            S_U_RD:
            begin
                if (cur_reg[IDX_W] || steps_reg == CNT_W'(MAX_BLOCKS))
                begin
                    idx_next   = (bud_reg < idx_reg) ? bud_reg : idx_reg;
                    ord_next   = ord_reg + ORD_W'(1);
                    state_next = S_F_MRG;
                end
                else
                begin
                    rd_addr    = cur_reg[IDX_W-1:0];
                    state_next = S_U_CHK;
                end
            end
            S_U_CHK:
            begin
                if (cur_reg[IDX_W-1:0] == bud_reg)
                begin
                    if (prev_reg[IDX_W])
                    begin
                        head_we = 1'b1;
                        head_wa = ord_reg;
                        head_wd = link_rd;
                    end
                    else
                    begin
                        link_we = 1'b1;
                        link_wa = prev_reg[IDX_W-1:0];
                        link_wd = link_rd;
                    end
                    fm_we      = 1'b1;
                    fm_wa      = bud_reg;
                    idx_next   = (bud_reg < idx_reg) ? bud_reg : idx_reg;
                    ord_next   = ord_reg + ORD_W'(1);
                    state_next = S_F_MRG;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    steps_next = steps_reg + CNT_W'(1);
                    state_next = S_U_RD;
                end
            end
            S_F_PUSH:
            begin
                push_en    = 1'b1;
                push_idx   = idx_reg;
                push_ord   = ord_reg;
                res_next   = '{status: ST_OK, block_index: idx_reg, block_order: ord_reg};
                state_next = S_DONE;
            end
            S_I_START:
            begin
                if (usable_reg == '0)
                begin
                    res_next   = '{status: ST_OK, block_index: '0, block_order: '0};
                    state_next = S_DONE;
                end
                else if (usable_reg > CNT_W'(MAX_BLOCKS))
                begin
                    res_next   = '{status: ST_OVER, block_index: '0, block_order: '0};
                    state_next = S_DONE;
                end
                else
                begin
                    top_next   = fl_val;
                    area_next  = usable_reg;
                    push_en    = 1'b1;
                    push_idx   = '0;
                    push_ord   = fl_val;
                    start_next = fl_pow;
                    rem_next   = usable_reg - fl_pow;
                    res_next   = '{status: ST_OK, block_index: '0, block_order: fl_val};
                    state_next = S_I_TAIL;
                end
            end
            S_I_TAIL:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    push_en    = 1'b1;
                    push_idx   = start_reg[IDX_W-1:0];
                    push_ord   = fl_val;
                    start_next = start_reg + fl_pow;
                    rem_next   = rem_reg - fl_pow;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_en)
        begin
            link_we = 1'b1;
            link_wa = push_idx;
            link_wd = head_reg[push_ord];
            ord_we  = 1'b1;
            ord_wa  = push_idx;
            ord_wd  = push_ord;
            fm_we   = 1'b1;
            fm_wa   = push_idx;
            fm_wd   = 1'b1;
            head_we = 1'b1;
            head_wa = push_ord;
            head_wd = LINK_W'(push_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            init_reg  <= 1'b0;
            top_reg   <= '0;
            area_reg  <= '0;
            for (int k = 0; k < ORDER_LEVELS; k++)
            begin
                head_reg[k] <= NIL_LINK;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            init_reg  <= init_next;
            top_reg   <= top_next;
            area_reg  <= area_next;
            for (int k = 0; k < ORDER_LEVELS; k++)
            begin
                if (head_clr)
                begin
                    head_reg[k] <= NIL_LINK;
                end
                else if (head_we && head_wa == ORD_W'(k))
                begin
                    head_reg[k] <= head_wd;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        usable_reg <= usable_next;
        blk_reg    <= blk_next;
        ord_reg    <= ord_next;
        i_reg      <= i_next;
        idx_reg    <= idx_next;
        bud_reg    <= bud_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        steps_reg  <= steps_next;
        start_reg  <= start_next;
        rem_reg    <= rem_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        link_rd <= link_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_wa] <= ord_wd;
        end
        ord_rd <= ord_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            fm_mem[fm_wa] <= fm_wd;
        end
        fm_rd <= fm_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (am_we)
        begin
            am_mem[am_wa] <= am_wd;
        end
        am_rd <= am_mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: rtl/buddy_block_allocator.sv
// Buddy allocator over an area of fixed-size blocks, one LIFO free list per order.
// Request channel s_*: s_tuser = request type (alloc, free, init); s_tdata carries
// request_bytes and free_index. One response per alloc, free or init on m_*;
// request type 3 is taken and dropped without a response.
// Config channel cfg_*: index 0 total_blocks, index 1 header_bytes; always ready,
// write only while no request is in flight.
// One request at a time: s_tready is high only while the sequencer is idle.
// Steps, through the link/order/mark memories that share one read address:
//   alloc: size, scan of the orders from the fitting one up, pop, then the splits;
//   free: mark check, then per merge step a buddy read and a walk of the list of
//         that order up to the buddy, then the push of the merged block;
//   init: mark clearing pass over all 4096 entries, then the blocks pushed.
// After reset the same clearing pass runs before s_tready rises.
// The response sits in an output register; while m_tready is low the next
// request may be taken and runs up to its end, then waits for the register.
`default_nettype none
module buddy_block_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [23:0] request_bytes, [35:24] free_index
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [11:0] block_index, [15:12] block_order
    output logic [1:0]       m_tuser,   // [1:0] status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data
);
    import bba_pkg::*;

    logic [CNT_W-1:0] total_reg;
    logic [HDR_W-1:0] header_reg;
    logic             out_valid_reg;
    res_t             out_reg;
    req_t             req;
    res_t             res;
    logic             res_valid;
    logic             res_ready;

    assign cfg_ready = 1'b1;
    assign req       = '{req_type: s_tuser,
                         request_bytes: s_tdata[BYTES_W-1:0],
                         free_index: s_tdata[BYTES_W+IDX_W-1:BYTES_W]};
    assign res_ready = !out_valid_reg || m_tready;

    bba_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req          (req),
        .total_blocks (total_reg),
        .header_bytes (header_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= CNT_W'(4097);
            header_reg    <= HDR_W'(16);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TOTAL)
                begin
                    total_reg <= cfg_data;
                end
                else
                begin
                    header_reg <= cfg_data[HDR_W-1:0];
                end
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {out_reg.block_order, out_reg.block_index};

`ifndef SYNTHESIS
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == RQ_ALLOC || s_tuser == RQ_FREE
            || s_tuser == RQ_INIT)) |=> !s_tready)
        else $error("sequencer still ready after taking a request");

    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:12] < 4'(ORDER_LEVELS)))
        else $error("response order out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_NO_SPACE || m_tuser == ST_OVER))
            |-> (m_tdata == 16'd0))
        else $error("failed response carries a block");
`endif

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import bba_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [12:0] cfg_data = '0;

    buddy_block_allocator uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // allocator mirror
    logic [LINK_W-1:0] free_head [ORDER_LEVELS];
    logic [LINK_W-1:0] link_next [MAX_BLOCKS];
    logic [ORD_W-1:0]  blk_order [MAX_BLOCKS];
    bit                is_free [MAX_BLOCKS];
    bit                is_alloc [MAX_BLOCKS];
    int                top_ord;
    int                area_n;
    int                total_cfg = 4097;
    int                header_cfg = 16;
    int                live_blocks [$];

    res_t              expected_resp [$];
    int                errors = 0;
    int                hold_cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    function automatic void push_free(int idx, int o);
        if (idx >= MAX_BLOCKS || o >= ORDER_LEVELS)
        begin
            return;
        end
        link_next[idx] = free_head[o];
        free_head[o] = LINK_W'(idx);
        blk_order[idx] = ORD_W'(o);
        is_free[idx] = 1'b1;
    endfunction

    function automatic void unlink_free(int idx, int o);
        int cur;
        int prev;
        prev = -1;
        cur = free_head[o];
        for (int s = 0; s < MAX_BLOCKS && cur < MAX_BLOCKS; s++)
        begin
            if (cur == idx)
            begin
                if (prev < 0)
                begin
                    free_head[o] = link_next[cur];
                end
                else
                begin
                    link_next[prev] = link_next[cur];
                end
                is_free[cur] = 1'b0;
                return;
            end
            prev = cur;
            cur = link_next[cur];
        end
    endfunction

    function automatic void clear_area();
        for (int k = 0; k < ORDER_LEVELS; k++)
        begin
            free_head[k] = NIL_LINK;
        end
        for (int k = 0; k < MAX_BLOCKS; k++)
        begin
            is_free[k] = 1'b0;
            is_alloc[k] = 1'b0;
        end
        top_ord = 0;
        area_n = 0;
        live_blocks.delete();
    endfunction

    function automatic res_t predict_alloc(int bytes);
        res_t r;
        int sum;
        int blocks;
        int o;
        int h;
        r = '0;
        r.status = ST_NO_SPACE;
        sum = bytes + header_cfg;
        blocks = (sum + BLOCK_BYTES - 1) / BLOCK_BYTES;
        if (blocks == 0)
        begin
            blocks = 1;
        end
        o = 0;
        while ((1 << o) < blocks)
        begin
            o++;
        end
        for (int i = o; i <= top_ord && i < ORDER_LEVELS; i++)
        begin
            h = free_head[i];
            if (h < MAX_BLOCKS)
            begin
                free_head[i] = link_next[h];
                is_free[h] = 1'b0;
                for (int u = i; u > o; u--)
                begin
                    push_free(h + (1 << (u - 1)), u - 1);
                end
                blk_order[h] = ORD_W'(o);
                is_alloc[h] = 1'b1;
                live_blocks.push_back(h);
                r.status = ST_OK;
                r.block_index = IDX_W'(h);
                r.block_order = ORD_W'(o);
                break;
            end
        end
        return r;
    endfunction

    function automatic res_t predict_free(int idx);
        res_t r;
        int o;
        int sz;
        int bud;
        r = '0;
        if (!is_alloc[idx])
        begin
            r.status = ST_BAD_FREE;
            r.block_index = IDX_W'(idx);
            return r;
        end
        for (int k = 0; k < live_blocks.size(); k++)
        begin
            if (live_blocks[k] == idx)
            begin
                live_blocks.delete(k);
                break;
            end
        end
        o = blk_order[idx];
        is_alloc[idx] = 1'b0;
        while (o < top_ord && o + 1 < ORDER_LEVELS)
        begin
            sz = 1 << o;
            bud = idx ^ sz;
            if (bud >= MAX_BLOCKS || bud + sz > area_n)
            begin
                break;
            end
            if (!is_free[bud] || blk_order[bud] != o)
            begin
                break;
            end
            unlink_free(bud, o);
            if (bud < idx)
            begin
                idx = bud;
            end
            o++;
        end
        push_free(idx, o);
        r.status = ST_OK;
        r.block_index = IDX_W'(idx);
        r.block_order = ORD_W'(o);
        return r;
    endfunction

    function automatic res_t predict_init();
        res_t r;
        int usable;
        int top;
        int start;
        int rem;
        int o;
        r = '0;
        usable = (total_cfg > 0) ? total_cfg - 1 : 0;
        clear_area();
        if (usable > 0)
        begin
            top = 0;
            while ((usable >> (top + 1)) != 0)
            begin
                top++;
            end
            if (usable > MAX_BLOCKS || top > ORDER_LEVELS - 1 || top > 20)
            begin
                r.status = ST_OVER;
            end
            else
            begin
                start = 1 << top;
                rem = usable - start;
                top_ord = top;
                area_n = usable;
                push_free(0, top);
                while (rem != 0)
                begin
                    o = 0;
                    while ((rem >> (o + 1)) != 0)
                    begin
                        o++;
                    end
                    push_free(start, o);
                    start += 1 << o;
                    rem -= 1 << o;
                end
                r.block_order = ORD_W'(top);
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
        begin
            return 0;
        end
        else if (p < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // response sink: runs of ready, random stalls, and forced hold-offs
    initial
    begin
        int run;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else
            begin
                run = $urandom_range(1, 60);
                m_tready <= 1'b1;
                for (int c = 0; c < run && hold_cycles == 0; c++)
                begin
                    @(posedge clk);
                end
                run = pick_gap();
                if (run > 0 && hold_cycles == 0)
                begin
                    m_tready <= 1'b0;
                    for (int c = 0; c < run && hold_cycles == 0; c++)
                    begin
                        @(posedge clk);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_resp.size() == 0)
            begin
                $error("unexpected response status=%0d data=%h", m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                res_t e;
                e = expected_resp.pop_front();
                if (m_tuser !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, m_tuser);
                    errors++;
                end
                if (m_tdata[11:0] !== e.block_index)
                begin
                    $error("block_index exp %0d got %0d", e.block_index, m_tdata[11:0]);
                    errors++;
                end
                if (m_tdata[15:12] !== e.block_order)
                begin
                    $error("block_order exp %0d got %0d", e.block_order, m_tdata[15:12]);
                    errors++;
                end
            end
        end
    end

    task automatic send_req(input logic [1:0] kind, input int bytes, input int idx);
        int g;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {4'b0, idx[11:0], bytes[23:0]};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        case (kind)
            RQ_ALLOC: expected_resp.push_back(predict_alloc(bytes[23:0]));
            RQ_FREE:  expected_resp.push_back(predict_free(idx[11:0]));
            RQ_INIT:  expected_resp.push_back(predict_init());
            default: ;
        endcase
        g = pick_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_resp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[12:0];
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == CFG_TOTAL)
        begin
            total_cfg = value & 13'h1FFF;
        end
        else
        begin
            header_cfg = value & 12'hFFF;
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic free_live();
        int k;
        k = $urandom_range(0, live_blocks.size() - 1);
        send_req(RQ_FREE, $urandom, live_blocks[k]);
    endtask

    task automatic test_before_init();
        send_req(RQ_ALLOC, 0, 0);
        send_req(RQ_FREE, 0, 0);
        drain();
    endtask

    task automatic test_directed();
        int first;
        send_req(RQ_INIT, 0, 0);
        send_req(RQ_ALLOC, 0, 0);
        first = live_blocks[0];
        send_req(RQ_ALLOC, 24'hFFFFFF, 12'hFFF);
        send_req(RQ_ALLOC, 4096 - 16, 0);
        send_req(RQ_ALLOC, 4096 - 15, 0);
        send_req(RQ_ALLOC, 2048 * 4096, 0);
        send_req(RQ_FREE, 0, first);
        send_req(RQ_FREE, 0, first);
        send_req(RQ_FREE, 0, 4095);
        send_req(2'd3, 24'hFFFFFF, 12'hFFF);
        while (live_blocks.size() > 0)
        begin
            send_req(RQ_FREE, 0, live_blocks[0]);
        end
        send_req(RQ_ALLOC, 4096 * 4096 - 16, 0);
        drain();
    endtask

    task automatic test_area_edges();
        int sizes [6] = '{0, 1, 2, 3, 8191, 4098};
        foreach (sizes[i])
        begin
            write_cfg(CFG_TOTAL, sizes[i]);
            send_req(RQ_INIT, 0, 0);
            send_req(RQ_ALLOC, 0, 0);
            send_req(RQ_ALLOC, 0, 0);
            if (live_blocks.size() > 0)
            begin
                send_req(RQ_FREE, 0, live_blocks[0]);
            end
            drain();
        end
    endtask

    task automatic random_phase(input int total, input int hdr, input int n);
        int p;
        write_cfg(CFG_TOTAL, total);
        write_cfg(CFG_HEADER, hdr);
        send_req(RQ_INIT, 0, 0);
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 50 || (p < 85 && live_blocks.size() == 0))
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_req(RQ_ALLOC, $urandom, $urandom);
                end
                else
                begin
                    send_req(RQ_ALLOC, $urandom_range(0, 4096 * 6), $urandom);
                end
            end
            else if (p < 85)
            begin
                free_live();
            end
            else if (p < 93)
            begin
                send_req(RQ_FREE, $urandom, $urandom);
            end
            else if (p < 97)
            begin
                send_req(2'd3, $urandom, $urandom);
            end
            else
            begin
                send_req(RQ_INIT, $urandom, $urandom);
            end
        end
        drain();
    endtask

    task automatic test_random();
        random_phase(4097, 16, 250);
        random_phase(40, 0, 200);
        random_phase(2, 4095, 60);
        random_phase($urandom_range(2, 4097), $urandom_range(0, 4095), 200);
        random_phase($urandom_range(100, 300), $urandom_range(0, 200), 200);
    endtask

    task automatic test_backpressure();
        write_cfg(CFG_TOTAL, 4097);
        write_cfg(CFG_HEADER, 0);
        send_req(RQ_INIT, 0, 0);
        drain();
        hold_cycles = 500;
        for (int i = 0; i < 12; i++)
        begin
            send_req(RQ_ALLOC, $urandom_range(0, 9000), 0);
        end
        drain();
    endtask

    initial
    begin
        clear_area();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_init();
        test_directed();
        test_area_edges();
        test_backpressure();
        test_random();
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
